[hdl/bdef_pkg.sv]
// Package for the button debounce event framer.
// Holds frame constants, register indexes and the shared structs; depends on nothing.
package bdef_pkg;

	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned IDX_W     = 4;

	localparam logic [7:0] FRAME_START = 8'hF0;
	localparam logic [7:0] FRAME_COUNT = 8'h01;
	localparam logic [7:0] FRAME_LENB  = 8'h04;
	localparam logic [7:0] FRAME_STOP  = 8'hFF;
	localparam logic [7:0] STATE_NORMAL_CODE = 8'h01;
	localparam logic [7:0] STATE_DOWN_CODE   = 8'h02;

	localparam logic [15:0] LOCKOUT_RESET = 16'd200;
	localparam logic [7:0]  PORT_RESET    = 8'd0;
	localparam logic [7:0]  DEVICE_RESET  = 8'd10;
	localparam logic [7:0]  PRESS_RESET   = 8'd1;
	localparam logic [7:0]  RELEASE_RESET = 8'd2;

	localparam logic [2:0] REG_LOCKOUT = 3'd0;
	localparam logic [2:0] REG_PORT    = 3'd1;
	localparam logic [2:0] REG_DEVICE  = 3'd2;
	localparam logic [2:0] REG_PRESS   = 3'd3;
	localparam logic [2:0] REG_RELEASE = 3'd4;

	typedef struct packed {
		logic        press;
		logic [15:0] total;
	} frame_desc_t;

	typedef struct packed {
		logic [7:0] port_number;
		logic [7:0] device_code;
		logic [7:0] press_code;
		logic [7:0] release_code;
	} frame_cfg_t;

endpackage

[hdl/bdef_front.sv]
// Front end: takes ticks, runs the lockout and press count, queues frame descriptors.
// Depends on bdef_pkg.
module bdef_front import bdef_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        level,
	input  logic [15:0] lockout_ticks,
	input  logic        queue_full,
	output logic        push,
	output frame_desc_t push_desc
);

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd1,
		MODE_DOWN    = 2'd2,
		MODE_LOCKOUT = 2'd3
	} mode_t;

	mode_t       mode_q;
	logic        held_q;
	logic [15:0] elapsed_q;
	logic [15:0] total_q;
	logic        take;
	logic        edge_hit;
	logic [15:0] total_next;

	assign in_stall   = queue_full;
	assign take       = in_valid && !queue_full;
	assign edge_hit   = (mode_q != MODE_LOCKOUT) && (level != held_q);
	assign total_next = level ? total_q : total_q + 16'd1;
	assign push       = take && edge_hit;
	assign push_desc  = '{press: !level, total: total_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			held_q    <= 1'b1;
			elapsed_q <= '0;
			total_q   <= '0;
		end else if (take) begin
			case (mode_q)
				MODE_LOCKOUT: begin
					if (elapsed_q >= lockout_ticks) begin
						mode_q <= held_q ? MODE_NORMAL : MODE_DOWN;
					end else begin
						elapsed_q <= elapsed_q + 16'd1;
					end
				end
				default: begin
					if (edge_hit) begin
						held_q    <= level;
						mode_q    <= MODE_LOCKOUT;
						elapsed_q <= '0;
						total_q   <= total_next;
					end
				end
			endcase
		end
	end

endmodule

[hdl/bdef_queue.sv]
// Short descriptor queue between front and back ends.
// Depends on bdef_pkg.
module bdef_queue import bdef_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	input  logic        pop,
	output logic        full,
	output logic        head_valid,
	output frame_desc_t head_desc
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_desc_t      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_desc  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/bdef_back.sv]
// Back end: serialises the head descriptor into a ten-byte frame, one byte a cycle unless stalled.
// Depends on bdef_pkg.
module bdef_back import bdef_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  frame_desc_t head_desc,
	input  frame_cfg_t  cfg,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_end
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             end_q;
	logic             load;
	logic [7:0]       byte_d;

	assign load       = head_valid && (!out_valid_q || !out_stall);
	assign pop        = load && (idx_q == IDX_LAST);
	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign frame_end  = end_q;

	always_comb begin
		case (idx_q)
			4'd0:    byte_d = FRAME_START;
			4'd1:    byte_d = FRAME_COUNT;
			4'd2:    byte_d = cfg.device_code;
			4'd3:    byte_d = cfg.port_number;
			4'd4:    byte_d = FRAME_LENB;
			4'd5:    byte_d = head_desc.press ? STATE_DOWN_CODE : STATE_NORMAL_CODE;
			4'd6:    byte_d = head_desc.press ? cfg.press_code : cfg.release_code;
			4'd7:    byte_d = head_desc.total[7:0];
			4'd8:    byte_d = head_desc.total[15:8];
			default: byte_d = FRAME_STOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			end_q  <= (idx_q == IDX_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/button_debounce_event_framer.sv]
// Button debounce event framer, top level.
// Holds the configuration registers and joins bdef_front, bdef_queue and bdef_back.
// Depends on bdef_pkg.
//
// One tick is taken every clock cycle while the descriptor queue has room; a level
// change outside the lockout queues one frame, and the back end sends its ten bytes
// on the result channel at one byte a cycle while out_stall is low.
// Up to QUEUE_DEPTH frames wait between the two sides; ticks stall only while the
// queue is full. Configuration is written through cfg_we, cfg_index and cfg_data
// (lockout_ticks, port_number, device_code, press_code, release_code in index order).
module button_debounce_event_framer import bdef_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_end
);

	logic [15:0] lockout_q;
	frame_cfg_t  cfg_q;
	logic        queue_full;
	logic        push;
	frame_desc_t push_desc;
	logic        pop;
	logic        head_valid;
	frame_desc_t head_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q          <= LOCKOUT_RESET;
			cfg_q.port_number  <= PORT_RESET;
			cfg_q.device_code  <= DEVICE_RESET;
			cfg_q.press_code   <= PRESS_RESET;
			cfg_q.release_code <= RELEASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOCKOUT: lockout_q          <= cfg_data;
				REG_PORT:    cfg_q.port_number  <= cfg_data[7:0];
				REG_DEVICE:  cfg_q.device_code  <= cfg_data[7:0];
				REG_PRESS:   cfg_q.press_code   <= cfg_data[7:0];
				REG_RELEASE: cfg_q.release_code <= cfg_data[7:0];
				default:     ;
			endcase
		end
	end

	bdef_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.level         (level),
		.lockout_ticks (lockout_q),
		.queue_full    (queue_full),
		.push          (push),
		.push_desc     (push_desc)
	);

	bdef_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	bdef_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.cfg        (cfg_q),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule
